// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the route loop neighbor finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rslnf_pkg.sv =====
// ----------------------------------------------------------------------------
// rslnf_pkg
// Types and constants shared by the route loop neighbor finder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rslnf_pkg;

	localparam int FAILED_SET_DEPTH = 16;
	localparam int IDX_W = (FAILED_SET_DEPTH > 1) ? $clog2(FAILED_SET_DEPTH) : 1;
	localparam int CNT_W = $clog2(FAILED_SET_DEPTH + 1);

	// Number parser modes
	localparam logic [2:0] MODE_SEARCH  = 3'd0;
	localparam logic [2:0] MODE_ZERO    = 3'd1;
	localparam logic [2:0] MODE_DEC     = 3'd2;
	localparam logic [2:0] MODE_OCT     = 3'd3;
	localparam logic [2:0] MODE_HEXPFX  = 3'd4;
	localparam logic [2:0] MODE_HEX     = 3'd5;
	localparam logic [2:0] MODE_STOPPED = 3'd6;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	localparam logic [2:0] MATCH_FULL = 3'd4;

	// Controller to datapath
	typedef struct packed {
		logic step;
		logic check;
		logic advance;
		logic insert;
		logic emit_load;
		logic sum_load;
	} rslnf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fin_now;
		logic last_now;
		logic last_pend;
		logic dup;
		logic failed_now;
		logic fill_zero;
		logic hit;
		logic last_idx;
		logic out_free;
	} rslnf_status_t;

endpackage

// ===== rtl/rslnf_ram.sv =====
// ----------------------------------------------------------------------------
// rslnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rslnf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rslnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rslnf_ctrl
// Sequencer: byte step, node check, set search, result and summary loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rslnf_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  rslnf_pkg::rslnf_status_t st,
	output rslnf_pkg::rslnf_cmd_t    cmd
);
	import rslnf_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_CMP    = 3'd3;
	localparam logic [2:0] S_INSERT = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_SUM    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.step = 1'b1;
					if (st.fin_now) begin
						state_d = S_CHECK;
					end else if (st.last_now) begin
						state_d = S_SUM;
					end
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (st.dup) begin
					state_d = st.last_pend ? S_SUM : S_IDLE;
				end else if (st.failed_now) begin
					state_d = st.fill_zero ? S_INSERT : S_READ;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (st.hit) begin
					state_d = S_EMIT;
				end else if (st.last_idx) begin
					state_d = S_INSERT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_load = 1'b1;
					state_d       = st.last_pend ? S_SUM : S_IDLE;
				end
			end
			S_SUM: begin
				if (st.out_free) begin
					cmd.sum_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_IMP(a_one_action, clk, arst_n, 1'b1, $onehot0({cmd.step, cmd.emit_load, cmd.sum_load}))
	`ASSERT_NXT(a_hit_emits, clk, arst_n, (state_q == S_CMP) && st.hit, state_q == S_EMIT)

endmodule

// ===== rtl/rslnf_dp.sv =====
// ----------------------------------------------------------------------------
// rslnf_dp
// Parser state, node bookkeeping, failed neighbor set and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rslnf_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rslnf_pkg::rslnf_cmd_t    cmd,
	output rslnf_pkg::rslnf_status_t st,
	input  logic [63:0]             own_node,
	input  logic [7:0]              char_byte,
	input  logic                    last_char,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [63:0]             node_id,
	output logic                    is_failed_neighbor,
	output logic                    first_time_failed,
	output logic                    end_of_route,
	output logic [15:0]             route_length,
	output logic [15:0]             failed_total,
	output logic                    set_overflow
);
	import rslnf_pkg::*;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, 4'(c - CH_0)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [7:0] marker_char(input logic [1:0] k);
		logic [7:0] r;
		unique case (k)
			2'd0: r = CH_I;
			2'd1: r = CH_P;
			2'd2: r = CH_N;
			2'd3: r = CH_COLON;
			default: r = CH_I;
		endcase
		return r;
	endfunction

	// Parser state
	logic [2:0]  match_q;
	logic [2:0]  mode_q;
	logic [63:0] value_q;
	logic [63:0] fin_value_q;
	logic        last_q;

	// Node state
	logic [63:0]      last_acc_q;
	logic             after_own_q;
	logic [15:0]      acc_cnt_q;
	logic [15:0]      fail_cnt_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] idx_q;
	logic             overflow_q;
	logic             failed_q;
	logic             first_q;

	// Result register
	logic        out_valid_q;
	logic [63:0] node_id_q;
	logic        failed_out_q;
	logic        first_out_q;
	logic        end_out_q;
	logic [15:0] len_out_q;
	logic [15:0] ftot_out_q;
	logic        ovf_out_q;

	logic [63:0] rd_data;

	// Byte step combinational terms
	logic [4:0]  hx;
	logic [3:0]  dval;
	logic        is_dec;
	logic        is_oct;
	logic [67:0] prod;
	logic [3:0]  acc_d;
	logic [67:0] acc_sum;
	logic [63:0] acc_val;
	logic        consumed;
	logic        num_active;
	logic        fin_byte;
	logic [63:0] fin_val;
	logic [2:0]  n_mode;
	logic [63:0] n_val;
	logic [2:0]  n_match;
	logic        new_active;
	logic        fin_last;
	logic [63:0] fin_sel;

	logic set_full;
	logic fail_hit;
	logic out_xfer;

	always_comb begin
		hx      = hex_digit(char_byte);
		dval    = 4'(char_byte - CH_0);
		is_dec  = (char_byte >= CH_0) && (char_byte <= CH_9);
		is_oct  = (char_byte >= CH_0) && (char_byte <= CH_7);
		unique case (mode_q)
			MODE_DEC: prod = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1);
			MODE_OCT: prod = {4'b0, value_q} << 3;
			default:  prod = {4'b0, value_q} << 4;
		endcase
		acc_d   = (mode_q == MODE_HEX) ? hx[3:0] : dval;
		acc_sum = prod + {64'b0, acc_d};
		acc_val = (|acc_sum[67:64]) ? '1 : acc_sum[63:0];

		consumed = 1'b0;
		n_mode   = mode_q;
		n_val    = value_q;
		n_match  = match_q;
		fin_byte = 1'b0;
		fin_val  = value_q;

		unique case (mode_q)
			MODE_ZERO: begin
				if (char_byte == CH_X_LO || char_byte == CH_X_UP) begin
					n_mode   = MODE_HEXPFX;
					consumed = 1'b1;
				end else if (is_oct) begin
					n_mode   = MODE_OCT;
					n_val    = {60'b0, dval};
					consumed = 1'b1;
				end
			end
			MODE_DEC: begin
				if (is_dec) begin
					n_val    = acc_val;
					consumed = 1'b1;
				end
			end
			MODE_OCT: begin
				if (is_oct) begin
					n_val    = acc_val;
					consumed = 1'b1;
				end
			end
			MODE_HEXPFX: begin
				if (hx[4]) begin
					n_mode   = MODE_HEX;
					n_val    = {60'b0, hx[3:0]};
					consumed = 1'b1;
				end
			end
			MODE_HEX: begin
				if (hx[4]) begin
					n_val    = acc_val;
					consumed = 1'b1;
				end
			end
			default: begin
			end
		endcase

		num_active = (mode_q != MODE_SEARCH) && (mode_q != MODE_STOPPED);
		if (num_active && !consumed) begin
			// A bare hex prefix completes as zero
			fin_byte = 1'b1;
			fin_val  = (mode_q == MODE_HEXPFX) ? '0 : value_q;
			n_mode   = MODE_SEARCH;
			n_val    = '0;
		end

		if (mode_q == MODE_SEARCH || fin_byte) begin
			if (char_byte == CH_NUL) begin
				n_mode = MODE_STOPPED;
			end else if (match_q == MATCH_FULL) begin
				n_match = '0;
				if (is_dec) begin
					n_mode = (char_byte == CH_0) ? MODE_ZERO : MODE_DEC;
					n_val  = {60'b0, dval};
				end else begin
					n_mode = MODE_STOPPED;
				end
			end else if (char_byte == marker_char(match_q[1:0])) begin
				n_match = match_q + 3'd1;
			end else begin
				n_match = (char_byte == CH_I) ? 3'd1 : 3'd0;
			end
		end

		new_active = (n_mode != MODE_SEARCH) && (n_mode != MODE_STOPPED);
		fin_last   = last_char && new_active;
		fin_sel    = fin_byte ? fin_val : ((n_mode == MODE_HEXPFX) ? '0 : n_val);
	end

	assign set_full = (fill_q == CNT_W'(FAILED_SET_DEPTH));
	assign fail_hit = (rd_data == fin_value_q);
	assign out_xfer = out_valid_q && !out_stall;

	always_comb begin
		st            = '0;
		st.fin_now    = fin_byte || fin_last;
		st.last_now   = last_char;
		st.last_pend  = last_q;
		st.dup        = (fin_value_q == last_acc_q);
		st.failed_now = (own_node != '0) && after_own_q;
		st.fill_zero  = (fill_q == '0);
		st.hit        = fail_hit;
		st.last_idx   = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
		st.out_free   = !out_valid_q || !out_stall;
	end

	rslnf_ram #(
		.WIDTH(64),
		.DEPTH(FAILED_SET_DEPTH)
	) u_set (
		.clk  (clk),
		.we   (cmd.insert && !set_full),
		.waddr(fill_q[IDX_W-1:0]),
		.wdata(fin_value_q),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			mode_q  <= MODE_SEARCH;
			value_q <= '0;
			last_q  <= 1'b0;
		end else if (cmd.step) begin
			last_q <= last_char;
			if (last_char) begin
				match_q <= '0;
				mode_q  <= MODE_SEARCH;
				value_q <= '0;
			end else begin
				match_q <= n_match;
				mode_q  <= n_mode;
				value_q <= n_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && (fin_byte || fin_last)) begin
			fin_value_q <= fin_sel;
		end
	end

	// Node bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_acc_q  <= '0;
			after_own_q <= 1'b0;
			acc_cnt_q   <= '0;
			fail_cnt_q  <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			overflow_q  <= 1'b0;
			failed_q    <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			if (cmd.check) begin
				idx_q   <= '0;
				first_q <= 1'b0;
				if (fin_value_q != last_acc_q) begin
					last_acc_q <= fin_value_q;
					if (acc_cnt_q != '1) begin
						acc_cnt_q <= acc_cnt_q + 16'd1;
					end
					if (own_node == '0) begin
						after_own_q <= 1'b0;
						failed_q    <= 1'b0;
					end else if (after_own_q) begin
						after_own_q <= 1'b0;
						failed_q    <= 1'b1;
						if (fail_cnt_q != '1) begin
							fail_cnt_q <= fail_cnt_q + 16'd1;
						end
					end else begin
						after_own_q <= (fin_value_q == own_node);
						failed_q    <= 1'b0;
					end
				end
			end
			if (cmd.advance) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.insert) begin
				if (set_full) begin
					overflow_q <= 1'b1;
				end else begin
					fill_q  <= fill_q + CNT_W'(1);
					first_q <= 1'b1;
				end
			end
			if (cmd.sum_load) begin
				last_acc_q  <= '0;
				after_own_q <= 1'b0;
				acc_cnt_q   <= '0;
				fail_cnt_q  <= '0;
				fill_q      <= '0;
				overflow_q  <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.sum_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			node_id_q    <= fin_value_q;
			failed_out_q <= failed_q;
			first_out_q  <= first_q;
			end_out_q    <= 1'b0;
			len_out_q    <= acc_cnt_q;
			ftot_out_q   <= fail_cnt_q;
			ovf_out_q    <= overflow_q;
		end else if (cmd.sum_load) begin
			node_id_q    <= '0;
			failed_out_q <= 1'b0;
			first_out_q  <= 1'b0;
			end_out_q    <= 1'b1;
			len_out_q    <= acc_cnt_q;
			ftot_out_q   <= fail_cnt_q;
			ovf_out_q    <= overflow_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign node_id            = node_id_q;
	assign is_failed_neighbor = failed_out_q;
	assign first_time_failed  = first_out_q;
	assign end_of_route       = end_out_q;
	assign route_length       = len_out_q;
	assign failed_total       = ftot_out_q;
	assign set_overflow       = ovf_out_q;

	`ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CNT_W'(FAILED_SET_DEPTH))
	`ASSERT_NXT(a_sum_clears, clk, arst_n, cmd.sum_load, (fill_q == '0) && !after_own_q && (acc_cnt_q == '0))

endmodule

// ===== rtl/route_string_loop_neighbor_finder.sv =====
// ----------------------------------------------------------------------------
// route_string_loop_neighbor_finder
// Scans a route text for "ipn:" node numbers and reports failed neighbors.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------
// in      | sink      | in_valid/in_stall  | char_byte, last_char
// out     | source    | out_valid/out_stall| node_id, flags, counts, set_overflow
// cfg     | sink      | cfg_we             | cfg_wdata (own_node)
//
// A byte that does not complete a number needs only its step in the idle state.
// A completed number adds a check step and, unless it repeats the last node,
// a result load that waits for a free output; a failed neighbor also reads
// and compares each stored entry of the set, then stores it or flags a full
// set if it was not found. After the last byte a summary load follows.
// Reset clears the parser, counters and the set fill count; own_node is 0.
// A stalled output holds its result; input is stalled until a byte's work ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module route_string_loop_neighbor_finder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        last_char,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] node_id,
	output logic        is_failed_neighbor,
	output logic        first_time_failed,
	output logic        end_of_route,
	output logic [15:0] route_length,
	output logic [15:0] failed_total,
	output logic        set_overflow
);
	import rslnf_pkg::*;

	logic [63:0]   own_node_q;
	rslnf_cmd_t    cmd;
	rslnf_status_t st;

	// own_node register: a zero value turns failed neighbor detection off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
		end else if (cfg_we) begin
			own_node_q <= cfg_wdata;
		end
	end

	// Sequencer: accepts a byte only when idle, then walks the check,
	// set search and result loads for whatever that byte completed
	rslnf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	// Datapath: parser, node bookkeeping, failed set and the result register
	// that decouples the output transfer from the parser
	rslnf_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.own_node          (own_node_q),
		.char_byte         (char_byte),
		.last_char         (last_char),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.node_id           (node_id),
		.is_failed_neighbor(is_failed_neighbor),
		.first_time_failed (first_time_failed),
		.end_of_route      (end_of_route),
		.route_length      (route_length),
		.failed_total      (failed_total),
		.set_overflow      (set_overflow)
	);

endmodule

// ===== test/route_string_loop_neighbor_finder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_string_loop_neighbor_finder_tb
// Feeds route texts byte by byte into the neighbor finder and checks every
// result against a local predictor of the parser, the duplicate filter and the
// failed neighbor set. A short directed part comes first. Randomized texts
// follow, mostly well-formed "ipn:" node lists with noise, under several
// own_node settings, with random idle bursts on the input and stall bursts on the output.
// ----------------------------------------------------------------------------

module route_string_loop_neighbor_finder_tb;

	import rslnf_pkg::*;

	localparam logic [63:0] ALL_ONES = {64{1'b1}};
	localparam int DRAIN_CYCLES = 64;
	localparam int LIMIT_NS = 2_000_000;
	localparam int NUM_PHASES = 6;
	localparam logic [31:0] MARKER = {CH_COLON, CH_N, CH_P, CH_I};
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_F_LO = 8'h66;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_F_UP = 8'h46;

	typedef enum int {FMT_DEC, FMT_HEX, FMT_OCT, FMT_DEC_WIDE, FMT_HEX_WIDE} node_fmt_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} route_byte_t;

	typedef struct packed {
		logic [63:0] node;
		logic        failed;
		logic        first;
		logic        summary;
		logic [15:0] length;
		logic [15:0] total;
		logic        overflow;
	} route_result_t;

	// ------------------------------------------------------------------------
	// Block ports
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_byte = '0;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] node_id;
	logic        is_failed_neighbor;
	logic        first_time_failed;
	logic        end_of_route;
	logic [15:0] route_length;
	logic [15:0] failed_total;
	logic        set_overflow;

	route_string_loop_neighbor_finder u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.char_byte          (char_byte),
		.last_char          (last_char),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.node_id            (node_id),
		.is_failed_neighbor (is_failed_neighbor),
		.first_time_failed  (first_time_failed),
		.end_of_route       (end_of_route),
		.route_length       (route_length),
		.failed_total       (failed_total),
		.set_overflow       (set_overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: shadow of own_node plus the whole route scan state
	// ------------------------------------------------------------------------
	logic [63:0] own_node_cfg;
	logic [2:0]  scan_match;
	logic [2:0]  num_mode;
	logic [63:0] num_value;
	logic [63:0] prev_node;
	logic        next_is_failed;
	logic [15:0] node_count;
	logic [15:0] failed_count;
	logic [63:0] failed_nodes [FAILED_SET_DEPTH];
	logic [FAILED_SET_DEPTH-1:0] failed_used;
	logic        set_full_seen;

	route_byte_t   pending_bytes[$];
	route_result_t expected_results[$];

	int  mismatch_count = 0;
	bit  idle_on = 1'b1;
	int  drv_gap = 0;
	int  mon_gap = 0;
	route_byte_t   drv_item;
	route_result_t got_result;
	route_result_t want_result;
	string separators = ", ;->/()";

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	function automatic string result_text(input route_result_t r);
		return $sformatf("node=%h nb=%b new=%b end=%b len=%0d fails=%0d ovf=%b",
			r.node, r.failed, r.first, r.summary, r.length, r.total, r.overflow);
	endfunction

	task automatic clear_route();
		scan_match = '0;
		num_mode = MODE_SEARCH;
		num_value = '0;
		prev_node = '0;
		next_is_failed = 1'b0;
		node_count = '0;
		failed_count = '0;
		failed_used = '0;
		set_full_seen = 1'b0;
	endtask

	function automatic int digit_of(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
		if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
		return -1;
	endfunction

	// Multiply-accumulate that sticks at all ones on overflow
	function automatic logic [63:0] scale_add(input logic [63:0] v, input logic [63:0] base,
			input logic [63:0] d);
		if (v > (ALL_ONES - d) / base) return ALL_ONES;
		return v * base + d;
	endfunction

	task automatic emit(input logic [63:0] node, input logic failed, input logic first,
			input logic summary);
		route_result_t r;
		r.node = node;
		r.failed = failed;
		r.first = first;
		r.summary = summary;
		r.length = node_count;
		r.total = failed_count;
		r.overflow = set_full_seen;
		expected_results.push_back(r);
	endtask

	// Complete the number in progress: drop a repeat, else accept and classify it
	task automatic close_number();
		logic [63:0] v;
		logic failed;
		logic first;
		logic found;
		int free_slot;
		v = num_value;
		failed = 1'b0;
		first = 1'b0;
		found = 1'b0;
		free_slot = -1;
		num_mode = MODE_SEARCH;
		num_value = '0;
		if (v != prev_node) begin
			prev_node = v;
			if (node_count != 16'hFFFF) node_count++;
			if (own_node_cfg != 0) begin
				if (next_is_failed) begin
					failed = 1'b1;
					next_is_failed = 1'b0;
					if (failed_count != 16'hFFFF) failed_count++;
					for (int i = 0; i < FAILED_SET_DEPTH; i++) begin
						if (failed_used[i]) begin
							if (failed_nodes[i] == v) found = 1'b1;
						end else if (free_slot < 0) begin
							free_slot = i;
						end
					end
					if (!found) begin
						if (free_slot >= 0) begin
							failed_nodes[free_slot] = v;
							failed_used[free_slot] = 1'b1;
							first = 1'b1;
						end else begin
							set_full_seen = 1'b1;
						end
					end
				end else begin
					next_is_failed = (v == own_node_cfg);
				end
			end else begin
				next_is_failed = 1'b0;
			end
			emit(v, failed, first, 1'b0);
		end
	endtask

	// Offer a byte to the number in progress; taken is low if it ends the number
	task automatic offer_digit(input logic [7:0] c, output bit taken);
		int h;
		h = digit_of(c);
		taken = 1'b0;
		case (num_mode)
			MODE_ZERO: begin
				if (c == CH_X_LO || c == CH_X_UP) begin
					num_mode = MODE_HEXPFX;
					taken = 1'b1;
				end else if (c >= CH_0 && c <= CH_7) begin
					num_mode = MODE_OCT;
					num_value = c - CH_0;
					taken = 1'b1;
				end
			end
			MODE_DEC: begin
				if (c >= CH_0 && c <= CH_9) begin
					num_value = scale_add(num_value, 64'd10, c - CH_0);
					taken = 1'b1;
				end
			end
			MODE_OCT: begin
				if (c >= CH_0 && c <= CH_7) begin
					num_value = scale_add(num_value, 64'd8, c - CH_0);
					taken = 1'b1;
				end
			end
			MODE_HEXPFX: begin
				if (h >= 0) begin
					num_mode = MODE_HEX;
					num_value = h;
					taken = 1'b1;
				end else begin
					num_value = '0;
				end
			end
			MODE_HEX: begin
				if (h >= 0) begin
					num_value = scale_add(num_value, 64'd16, h);
					taken = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic scan_char(input logic [7:0] c);
		if (c == CH_NUL) begin
			num_mode = MODE_STOPPED;
		end else if (scan_match >= MATCH_FULL) begin
			scan_match = '0;
			if (c >= CH_0 && c <= CH_9) begin
				num_mode = (c == CH_0) ? MODE_ZERO : MODE_DEC;
				num_value = c - CH_0;
			end else begin
				num_mode = MODE_STOPPED;
			end
		end else if (c == MARKER[scan_match*8 +: 8]) begin
			scan_match++;
		end else begin
			scan_match = (c == CH_I) ? 3'd1 : 3'd0;
		end
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic last);
		bit taken;
		if (num_mode != MODE_SEARCH && num_mode != MODE_STOPPED) begin
			offer_digit(c, taken);
			if (!taken) begin
				close_number();
				scan_char(c);
			end
		end else if (num_mode == MODE_SEARCH) begin
			scan_char(c);
		end
		if (last) begin
			// a number still open at the final byte completes before the summary
			if (num_mode != MODE_SEARCH && num_mode != MODE_STOPPED) begin
				if (num_mode == MODE_HEXPFX) num_value = '0;
				close_number();
			end
			emit('0, 1'b0, 1'b0, 1'b1);
			clear_route();
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the head of the pending queue, predict on each transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_byte(char_byte, last_char);
				drv_item = pending_bytes.pop_front();
				if (idle_on && $urandom_range(0, 9) == 0) drv_gap = $urandom_range(1, 17);
			end
			// hold the payload while stalled, else advance or idle
			if (!(in_valid && in_stall)) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					drv_item = pending_bytes[0];
					in_valid <= 1'b1;
					char_byte <= drv_item.ch;
					last_char <= drv_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each output transfer with the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_result = {node_id, is_failed_neighbor, first_time_failed, end_of_route,
					route_length, failed_total, set_overflow};
				if (expected_results.size() == 0) begin
					report_mismatch({"unexpected result ", result_text(got_result)});
				end else begin
					want_result = expected_results.pop_front();
					if (got_result !== want_result) begin
						report_mismatch({"got ", result_text(got_result),
							" want ", result_text(want_result)});
					end
				end
			end
			// stall bursts of random length
			if (mon_gap > 0) begin
				mon_gap--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				mon_gap = $urandom_range(0, 16);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_literal(input string s);
		for (int i = 0; i < s.len(); i++) begin
			pending_bytes.push_back({s[i], (i == s.len() - 1) ? 1'b1 : 1'b0});
		end
	endtask

	function automatic string node_text(input logic [63:0] v, input node_fmt_t fmt);
		string s;
		string pfx;
		pfx = $urandom_range(0, 1) ? "0X" : "0x";
		case (fmt)
			FMT_DEC: s = $sformatf("%0d", v);
			FMT_HEX: begin
				s = $sformatf("%0h", v);
				if ($urandom_range(0, 1)) s = s.toupper();
				s = {pfx, s};
			end
			FMT_OCT: s = {"0", $sformatf("%0o", v)};
			FMT_DEC_WIDE: begin
				// 21 digits always exceed 64 bits
				s = "1";
				repeat (20) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
			end
			default: begin
				s = {pfx, "1"};
				repeat (16) s = {s, $sformatf("%0h", $urandom_range(0, 15))};
			end
		endcase
		return s;
	endfunction

	// Build one text of node tokens, broken markers and noise, then queue it whole
	task automatic queue_text(input int own_pct, input int pool_max, input int tokens,
			input bit closed, output int n_bytes);
		route_byte_t text[$];
		route_byte_t tail;
		string s;
		logic [63:0] node;
		node_fmt_t fmt;
		int pick;
		int r;
		for (int t = 0; t < tokens; t++) begin
			pick = $urandom_range(0, 99);
			s = "";
			if (pick < 80) begin
				if ($urandom_range(0, 99) < own_pct && own_node_cfg != 0) begin
					node = own_node_cfg;
				end else begin
					r = $urandom_range(0, 19);
					if (r < 13) node = $urandom_range(1, pool_max);
					else if (r < 15) node = '0;
					else if (r < 18) node = {$urandom, $urandom};
					else node = ALL_ONES;
				end
				r = $urandom_range(0, 19);
				if (r < 8) fmt = FMT_DEC;
				else if (r < 13) fmt = FMT_HEX;
				else if (r < 17) fmt = FMT_OCT;
				else if (r < 19) fmt = FMT_DEC_WIDE;
				else fmt = FMT_HEX_WIDE;
				s = {"ipn:", node_text(node, fmt)};
			end else if (pick < 88) begin
				case ($urandom_range(0, 3))
					0: s = "ipn";
					1: s = "ipnn:";
					2: s = "iip:";
					default: s = "IPN:";
				endcase
				s = {s, $sformatf("%0d", $urandom_range(1, 99))};
			end else if (pick < 90) begin
				// marker with no digit after it stops the scan
				s = "ipn:z";
			end else begin
				repeat ($urandom_range(1, 4)) text.push_back({8'($urandom_range(0, 255)), 1'b0});
			end
			for (int i = 0; i < s.len(); i++) text.push_back({s[i], 1'b0});
			if (t != tokens - 1 || $urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					text.push_back({separators[$urandom_range(0, separators.len() - 1)], 1'b0});
				end else if (r < 96) begin
					text.push_back({8'($urandom_range(1, 255)), 1'b0});
				end else if (r == 99) begin
					text.push_back({CH_NUL, 1'b0});
				end
			end
		end
		if (text.size() == 0) text.push_back({separators[0], 1'b0});
		if (closed) begin
			tail = text.pop_back();
			tail.last = 1'b1;
			text.push_back(tail);
		end
		n_bytes = text.size();
		foreach (text[i]) pending_bytes.push_back(text[i]);
	endtask

	// Hold until every byte is transferred and every result has come, then drain
	task automatic wait_route_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_own_node(input logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		own_node_cfg = v;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	logic [63:0] phase_own [NUM_PHASES];
	int phase_budget [NUM_PHASES];
	int phase_bias [NUM_PHASES];

	initial begin
		int phase_bytes;
		int n;
		int tokens;
		own_node_cfg = '0;
		clear_route();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: repeated 'i' before the marker, upper case hex prefix, hex digit
		// ended by a marker, octal at the final byte, "08" splitting into 0 and '8',
		// and a bare "0x" at the final byte.
		queue_literal("iipn:0Xaipn:017");
		queue_literal("ipn:08ipn:0x");
		wait_route_idle();

		// own_node settings: both extremes, a small value with a loop-heavy mix
		// to fill the failed set, a random value, and a final quiet phase.
		phase_own[0] = 64'd7;          phase_budget[0] = 80;  phase_bias[0] = 25;
		phase_own[1] = ALL_ONES;       phase_budget[1] = 70;  phase_bias[1] = 25;
		phase_own[2] = '0;             phase_budget[2] = 60;  phase_bias[2] = 25;
		phase_own[3] = 64'd3;          phase_budget[3] = 450; phase_bias[3] = 50;
		phase_own[4] = {$urandom, $urandom};
		phase_budget[4] = 70;          phase_bias[4] = 30;
		phase_own[5] = 64'd1;          phase_budget[5] = 70;  phase_bias[5] = 25;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// the block is idle here: every result has come and the drain has passed
			write_own_node(phase_own[p]);
			if (p == NUM_PHASES - 1) idle_on = 1'b0;
			phase_bytes = 0;
			while (phase_bytes < phase_budget[p]) begin
				if (phase_bias[p] >= 50) tokens = $urandom_range(50, 90);
				else if ($urandom_range(0, 7) == 0) tokens = $urandom_range(20, 50);
				else tokens = $urandom_range(1, 8);
				queue_text(phase_bias[p], (phase_bias[p] >= 50) ? 40 : 24, tokens, 1'b1, n);
				phase_bytes += n;
			end
			// sometimes leave a text open so the next setting applies mid-text
			if ($urandom_range(0, 1)) queue_text(phase_bias[p], 24, 1, 1'b0, n);
			wait_route_idle();
		end

		if (expected_results.size() != 0) report_mismatch("results still expected at the end");
		if (mismatch_count == 0) begin
			$display("[route_string_loop_neighbor_finder] OK");
		end else begin
			$display("[route_string_loop_neighbor_finder] ERROR");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("[route_string_loop_neighbor_finder] ERROR");
		$finish;
	end

endmodule
